@@ hw/rtl/twafm_pkg.sv @@
package twafm_pkg;

  // Defaults for the top level parameters
  localparam int DEF_WINDOW_SIZE       = 8;
  localparam int DEF_FAULT_COUNT_LIMIT = 4;

  // Field and bus widths
  localparam int SAMPLE_W = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 4;
  localparam int REG_IW   = APB_AW - 2;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IW-1:0] REG_BREAK_CODE = 2'd0;
  localparam logic [REG_IW-1:0] REG_SHORT_CODE = 2'd1;
  localparam logic [REG_IW-1:0] REG_OVERHEAT   = 2'd2;

  // Register reset values
  localparam logic signed [SAMPLE_W-1:0] RST_BREAK_CODE = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] RST_SHORT_CODE = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] RST_OVERHEAT   = 16'sh7FFF;

  // Configuration seen by the datapath
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] break_code;
    logic signed [SAMPLE_W-1:0] short_code;
    logic signed [SAMPLE_W-1:0] overheat_setpoint;
  } cfg_t;

  // Fault / overheat flag group
  typedef struct packed {
    logic brk;
    logic sht;
    logic ovh;
  } flags_t;

endpackage

@@ hw/rtl/twafm_regs.sv @@
module twafm_regs import twafm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [REG_IW-1:0] reg_idx;
  logic              wr_en;
  logic [SAMPLE_W-1:0] rd_val;

  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_o.break_code        <= RST_BREAK_CODE;
      cfg_o.short_code        <= RST_SHORT_CODE;
      cfg_o.overheat_setpoint <= RST_OVERHEAT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BREAK_CODE: cfg_o.break_code        <= pwdata[SAMPLE_W-1:0];
        REG_SHORT_CODE: cfg_o.short_code        <= pwdata[SAMPLE_W-1:0];
        REG_OVERHEAT:   cfg_o.overheat_setpoint <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, sign extended to the bus
  always_comb begin
    case (reg_idx)
      REG_BREAK_CODE: rd_val = cfg_o.break_code;
      REG_SHORT_CODE: rd_val = cfg_o.short_code;
      REG_OVERHEAT:   rd_val = cfg_o.overheat_setpoint;
      default:        rd_val = '0;
    endcase
  end

  assign prdata = {{(APB_DW-SAMPLE_W){rd_val[SAMPLE_W-1]}}, rd_val};

endmodule

@@ hw/rtl/twafm_win_mem.sv @@
module twafm_win_mem import twafm_pkg::*; #(
  parameter int DEPTH = DEF_WINDOW_SIZE
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [SAMPLE_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [SAMPLE_W-1:0]        rdata_o
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    valid_q;
  logic [SAMPLE_W-1:0] rd_data_q;
  logic                rd_valid_q;

  // Sample storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_data_q <= mem[raddr_i];
  end

  // Written-entry marks; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_valid_q ? rd_data_q : '0;

endmodule

@@ hw/rtl/twafm_div.sv @@
module twafm_div import twafm_pkg::*; #(
  parameter int DW      = SAMPLE_W + $clog2(DEF_WINDOW_SIZE),
  parameter int DIVISOR = DEF_WINDOW_SIZE
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  // Reciprocal scaling: quotient = (dividend * MUL) >> SH. MUL overshoots
  // 2^SH / DIVISOR by less than one, so the result is exact below 2^DW.
  localparam int          LW    = $clog2(DIVISOR);
  localparam int          SH    = DW + LW;
  localparam int          PW    = 2 * DW + 1;
  localparam longint      MUL_L = ((longint'(1) <<< SH) + longint'(DIVISOR) - 1)
                                  / longint'(DIVISOR);
  localparam logic [DW:0] MUL   = (DW + 1)'(MUL_L);

  logic [DW-1:0] dvd_q;
  logic [PW-1:0] prod_q;
  logic          stage_q;
  logic          done_q;

  // Capture the dividend, then one registered multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q   <= '0;
      prod_q  <= '0;
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= start_i;
      done_q  <= stage_q;
      if (start_i) begin
        dvd_q <= dividend_i;
      end
      if (stage_q) begin
        prod_q <= dvd_q * MUL;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = DW'(prod_q >> SH);

endmodule

@@ hw/rtl/temp_window_average_fault_monitor_top.sv @@
// Temperature window averager with fault vote.
// Input channel: one signed sample (tenths of a degree or a fault code) per
// request on in_valid_i/in_ready_o. Every request gives exactly one result on
// out_valid_o/out_ready_i: reported temperature, evaluated bit, sticky
// break/short/overheat flags and their new-event bits.
// Samples go round a window memory of WINDOW_SIZE entries. A sample landing
// at slot 0 triggers an evaluation: the window is walked through the single
// memory read port, fault codes are voted, and unless a vote reaches
// FAULT_COUNT_LIMIT the sum is divided by WINDOW_SIZE with a registered
// reciprocal multiply. One request is processed at a time; the next one is
// accepted while a finished result waits at the output.
// Reset clears the window (entries read as zero), write index, reported value
// and sticky flags, and loads the register defaults. A stalled receiver holds
// the result register; the block then finishes its current request and waits.
// Registers (APB, byte address 4*i): 0 break code, 1 short code,
// 2 overheat setpoint; write them only while the block is idle.
module temp_window_average_fault_monitor_top import twafm_pkg::*; #(
  parameter int WINDOW_SIZE       = DEF_WINDOW_SIZE,
  parameter int FAULT_COUNT_LIMIT = DEF_FAULT_COUNT_LIMIT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] temperature_o,
  output logic                       evaluated_o,
  output logic                       break_flag_o,
  output logic                       short_flag_o,
  output logic                       overheat_flag_o,
  output logic                       new_break_o,
  output logic                       new_short_o,
  output logic                       new_overheat_o,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_AW-1:0]          paddr,
  input  logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready
);

  localparam int IW = $clog2(WINDOW_SIZE);
  localparam int CW = $clog2(WINDOW_SIZE + 1);
  localparam int SW = SAMPLE_W + $clog2(WINDOW_SIZE);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_DRAIN, ST_DECIDE, ST_DIV, ST_FLAGS, ST_DONE
  } state_e;

  cfg_t                       cfg;
  state_e                     state_q;
  logic [IW-1:0]              idx_q;
  logic [IW-1:0]              rd_ptr_q;
  logic                       rd_vld_q;
  logic                       eval_q;
  logic [CW-1:0]              brk_cnt_q;
  logic [CW-1:0]              sht_cnt_q;
  logic signed [SW-1:0]       sum_q;
  logic                       brk_hit_q;
  logic                       sht_hit_q;
  logic signed [SAMPLE_W-1:0] rep_q;
  flags_t                     flags_q;
  flags_t                     new_q;
  flags_t                     newly;

  logic                       accept;
  logic [SAMPLE_W-1:0]        mem_rdata;
  logic                       brk_hit;
  logic                       sht_hit;
  logic                       sum_neg;
  logic [SW-1:0]              sum_mag;
  logic                       div_start;
  logic                       div_done;
  logic [SW-1:0]              div_quo;
  logic [SW-1:0]              div_signed;
  logic                       out_free;

  // Configuration registers
  twafm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sample window; written on accept, walked afterwards, so no overlap
  twafm_win_mem #(
    .DEPTH (WINDOW_SIZE)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (accept),
    .waddr_i (idx_q),
    .wdata_i (sample_i),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  // Mean of the window magnitude
  twafm_div #(
    .DW      (SW),
    .DIVISOR (WINDOW_SIZE)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;

  // Fault vote and mean sign handling
  assign brk_hit    = 32'(brk_cnt_q) >= 32'(FAULT_COUNT_LIMIT);
  assign sht_hit    = 32'(sht_cnt_q) >= 32'(FAULT_COUNT_LIMIT);
  assign sum_neg    = sum_q[SW-1];
  assign sum_mag    = sum_neg ? SW'(-sum_q) : SW'(sum_q);
  assign div_start  = (state_q == ST_DECIDE) && !brk_hit && !sht_hit;
  assign div_signed = sum_neg ? (~div_quo + 1'b1) : div_quo;

  // New events from this evaluation
  always_comb begin
    newly.brk = brk_hit_q && !flags_q.brk;
    newly.sht = sht_hit_q && !flags_q.sht;
    newly.ovh = (rep_q > cfg.overheat_setpoint) && !flags_q.ovh;
  end

  // Control sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      idx_q           <= '0;
      rd_ptr_q        <= '0;
      rd_vld_q        <= 1'b0;
      eval_q          <= 1'b0;
      brk_cnt_q       <= '0;
      sht_cnt_q       <= '0;
      sum_q           <= '0;
      brk_hit_q       <= 1'b0;
      sht_hit_q       <= 1'b0;
      rep_q           <= '0;
      flags_q         <= '0;
      new_q           <= '0;
      out_valid_o     <= 1'b0;
      temperature_o   <= '0;
      evaluated_o     <= 1'b0;
      break_flag_o    <= 1'b0;
      short_flag_o    <= 1'b0;
      overheat_flag_o <= 1'b0;
      new_break_o     <= 1'b0;
      new_short_o     <= 1'b0;
      new_overheat_o  <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_READ);

      // accumulate one window entry per cycle
      if (rd_vld_q) begin
        sum_q <= sum_q + {{(SW-SAMPLE_W){mem_rdata[SAMPLE_W-1]}}, mem_rdata};
        if (mem_rdata == cfg.break_code) begin
          brk_cnt_q <= brk_cnt_q + 1'b1;
        end
        if (mem_rdata == cfg.short_code) begin
          sht_cnt_q <= sht_cnt_q + 1'b1;
        end
      end

      // result taken; ST_DONE reloads it in the same cycle
      if (out_valid_o && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_o <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            idx_q     <= (idx_q == IW'(WINDOW_SIZE - 1)) ? '0 : idx_q + 1'b1;
            eval_q    <= (idx_q == '0);
            brk_cnt_q <= '0;
            sht_cnt_q <= '0;
            sum_q     <= '0;
            rd_ptr_q  <= '0;
            new_q     <= '0;
            state_q   <= (idx_q == '0) ? ST_READ : ST_DONE;
          end
        end
        ST_READ: begin
          rd_ptr_q <= rd_ptr_q + 1'b1;
          if (rd_ptr_q == IW'(WINDOW_SIZE - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          brk_hit_q <= brk_hit;
          sht_hit_q <= sht_hit;
          if (sht_hit) begin
            rep_q <= cfg.short_code;
          end else if (brk_hit) begin
            rep_q <= cfg.break_code;
          end
          state_q <= (brk_hit || sht_hit) ? ST_FLAGS : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            rep_q   <= div_signed[SAMPLE_W-1:0];
            state_q <= ST_FLAGS;
          end
        end
        ST_FLAGS: begin
          new_q   <= newly;
          flags_q <= flags_q | newly;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_o     <= 1'b1;
            temperature_o   <= rep_q;
            evaluated_o     <= eval_q;
            break_flag_o    <= flags_q.brk;
            short_flag_o    <= flags_q.sht;
            overheat_flag_o <= flags_q.ovh;
            new_break_o     <= new_q.brk;
            new_short_o     <= new_q.sht;
            new_overheat_o  <= new_q.ovh;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
